// File: rtl/sdes_pkg.sv
// sdes_pkg: shared types, constants and round functions for the 12-bit feistel cipher
// no dependencies; imported by every rtl module of the block

package sdes_pkg;

  localparam int unsigned BLK_W  = 12;
  localparam int unsigned HALF_W = 6;
  localparam int unsigned KEY_W  = 9;
  localparam int unsigned RK_W   = 8;
  localparam int unsigned ROT_W  = 4;
  localparam int unsigned RC_W   = 5;
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned MOD_W  = 7;

  localparam logic [BLK_W-1:0] FIXED_IV = 12'hE38;
  localparam logic [ROT_W-1:0] ROT_LAST = 4'd8;

  // register indexes on the config port
  localparam logic [2:0] REG_KEY    = 3'd0;
  localparam logic [2:0] REG_ROUNDS = 3'd1;
  localparam logic [2:0] REG_DECR   = 3'd2;
  localparam logic [2:0] REG_CHAIN  = 3'd3;
  localparam logic [2:0] REG_IV     = 3'd4;

  localparam logic [2:0] SBOX_ONE [16] = '{
    3'd5, 3'd2, 3'd1, 3'd6, 3'd3, 3'd4, 3'd7, 3'd0,
    3'd1, 3'd4, 3'd6, 3'd2, 3'd0, 3'd7, 3'd5, 3'd3
  };
  localparam logic [2:0] SBOX_TWO [16] = '{
    3'd4, 3'd0, 3'd6, 3'd5, 3'd7, 3'd1, 3'd3, 3'd2,
    3'd5, 3'd3, 3'd0, 3'd7, 3'd6, 3'd2, 3'd1, 3'd4
  };

  typedef struct packed {
    logic [KEY_W-1:0] cipher_key;
    logic [RC_W-1:0]  round_count;
    logic             decrypt_select;
    logic             chain_mode;
    logic [BLK_W-1:0] init_vector;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             step;
    logic             finish;
    logic             finish_round;
    logic [ROT_W-1:0] rot_start;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  // reduce a small value modulo the key length by repeated subtraction
  function automatic logic [ROT_W-1:0] mod_key(input logic [MOD_W-1:0] v);
    logic [MOD_W-1:0] r;
    r = v;
    for (int i = 0; i < 7; i++) begin
      if (r >= MOD_W'(KEY_W)) begin
        r = r - MOD_W'(KEY_W);
      end
    end
    return ROT_W'(r);
  endfunction

  // key rotated left by rot within 9 bits, then its upper 8 bits
  function automatic logic [RK_W-1:0] round_key(input logic [KEY_W-1:0] k,
                                                input logic [ROT_W-1:0] rot);
    logic [2*KEY_W-1:0] kk;
    kk = {k, k} << rot;
    return kk[2*KEY_W-1:KEY_W+1];
  endfunction

  function automatic logic [HALF_W-1:0] feistel_f(input logic [HALF_W-1:0] r,
                                                  input logic [RK_W-1:0] rk);
    logic [RK_W-1:0] x;
    x = {r[5], r[4], r[2], r[3], r[2], r[3], r[1], r[0]} ^ rk;
    return {SBOX_ONE[x[7:4]], SBOX_TWO[x[3:0]]};
  endfunction

  function automatic logic [BLK_W-1:0] swap_halves(input logic [BLK_W-1:0] b);
    return {b[HALF_W-1:0], b[BLK_W-1:HALF_W]};
  endfunction

  function automatic logic [BLK_W-1:0] feistel_round(input logic [BLK_W-1:0] b,
                                                     input logic [RK_W-1:0] rk);
    return {b[HALF_W-1:0], b[BLK_W-1:HALF_W] ^ feistel_f(b[HALF_W-1:0], rk)};
  endfunction

endpackage

// File: rtl/sdes_if.sv
// sdes_in_if / sdes_out_if: valid-ready channels carrying input and result words
// depends on nothing; used by the top level and its testbench

interface sdes_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] block_in;
  logic        restart_chain;

  modport source (output valid, block_in, restart_chain, input ready);
  modport sink   (input valid, block_in, restart_chain, output ready);
endinterface

interface sdes_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] block_out;

  modport source (output valid, block_out, input ready);
  modport sink   (input valid, block_out, output ready);
endinterface

// File: rtl/sdes_regs.sv
// sdes_regs: apb-style configuration register file
// depends on sdes_pkg

module sdes_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sdes_pkg::APB_AW-1:0] paddr,
  input  logic [sdes_pkg::APB_DW-1:0] pwdata,
  output logic [sdes_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output sdes_pkg::cfg_t              cfg_o
);
  import sdes_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_KEY:    cfg_d.cipher_key     = pwdata[KEY_W-1:0];
        REG_ROUNDS: cfg_d.round_count    = pwdata[RC_W-1:0];
        REG_DECR:   cfg_d.decrypt_select = pwdata[0];
        REG_CHAIN:  cfg_d.chain_mode     = pwdata[0];
        REG_IV:     cfg_d.init_vector    = pwdata[BLK_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KEY:    prdata = APB_DW'(cfg_q.cipher_key);
      REG_ROUNDS: prdata = APB_DW'(cfg_q.round_count);
      REG_DECR:   prdata = APB_DW'(cfg_q.decrypt_select);
      REG_CHAIN:  prdata = APB_DW'(cfg_q.chain_mode);
      REG_IV:     prdata = APB_DW'(cfg_q.init_vector);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cipher_key     <= '0;
      cfg_q.round_count    <= RC_W'(4);
      cfg_q.decrypt_select <= 1'b0;
      cfg_q.chain_mode     <= 1'b0;
      cfg_q.init_vector    <= FIXED_IV;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: rtl/sdes_ctrl.sv
// sdes_ctrl: sequencer for load, round steps and result write-back
// depends on sdes_pkg; drives sdes_dp through the command struct

module sdes_ctrl #(
  parameter int unsigned MAX_ROUNDS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sdes_pkg::cfg_t      cfg_i,
  input  sdes_pkg::dp_sts_t   sts_i,
  output sdes_pkg::dp_cmd_t   cmd_o
);
  import sdes_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ROUNDS + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] n_rounds;

  // saturate the configured round count
  always_comb begin
    if (32'(cfg_i.round_count) > MAX_ROUNDS) begin
      n_rounds = CNT_W'(MAX_ROUNDS);
    end else begin
      n_rounds = CNT_W'(cfg_i.round_count);
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.rot_start = cfg_i.decrypt_select ? mod_key(MOD_W'(n_rounds) - MOD_W'(1))
                                           : '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = n_rounds;
          state_d    = (n_rounds == '0) ? ST_FLUSH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_q > CNT_W'(1)) begin
          cmd_o.step = 1'b1;
          cnt_d      = cnt_q - CNT_W'(1);
        end else if (sts_i.out_free) begin
          // last round folds into the write-back
          cmd_o.finish       = 1'b1;
          cmd_o.finish_round = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: rtl/sdes_dp.sv
// sdes_dp: block, chaining and key-rotation registers plus one feistel round
// depends on sdes_pkg; commanded by sdes_ctrl

module sdes_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sdes_pkg::cfg_t             cfg_i,
  input  sdes_pkg::dp_cmd_t          cmd_i,
  output sdes_pkg::dp_sts_t          sts_o,
  input  logic [sdes_pkg::BLK_W-1:0] block_in_i,
  input  logic                       restart_chain_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [sdes_pkg::BLK_W-1:0] block_out_o
);
  import sdes_pkg::*;

  logic [BLK_W-1:0] block_q, block_d;
  logic [BLK_W-1:0] chain_q, chain_d;
  logic [BLK_W-1:0] held_q, held_d;
  logic [ROT_W-1:0] rot_q, rot_d, rot_next;
  logic [BLK_W-1:0] res_q, res_d;
  logic             res_valid_q, res_valid_d;

  logic [BLK_W-1:0] chain_eff, pre_blk, rnd_blk, src_blk, core_blk, result;
  logic             dec, cbc;

  assign dec = cfg_i.decrypt_select;
  assign cbc = cfg_i.chain_mode;

  assign chain_eff = restart_chain_i ? cfg_i.init_vector : chain_q;
  always_comb begin
    if (dec) begin
      pre_blk = swap_halves(block_in_i);
    end else if (cbc) begin
      pre_blk = block_in_i ^ chain_eff;
    end else begin
      pre_blk = block_in_i;
    end
  end

  assign rnd_blk  = feistel_round(block_q, round_key(cfg_i.cipher_key, rot_q));
  assign src_blk  = cmd_i.finish_round ? rnd_blk : block_q;
  assign core_blk = dec ? swap_halves(src_blk) : src_blk;
  assign result   = (cbc && dec) ? (core_blk ^ chain_q) : core_blk;

  // key window moves forward when encrypting, backward when decrypting
  always_comb begin
    if (dec) begin
      rot_next = (rot_q == '0) ? ROT_LAST : rot_q - ROT_W'(1);
    end else begin
      rot_next = (rot_q == ROT_LAST) ? '0 : rot_q + ROT_W'(1);
    end
  end

  always_comb begin
    block_d     = block_q;
    chain_d     = chain_q;
    held_d      = held_q;
    rot_d       = rot_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !out_ready_i;
    if (cmd_i.load) begin
      block_d = pre_blk;
      chain_d = chain_eff;
      held_d  = block_in_i;
      rot_d   = cmd_i.rot_start;
    end
    if (cmd_i.step) begin
      block_d = rnd_blk;
      rot_d   = rot_next;
    end
    if (cmd_i.finish) begin
      res_d       = result;
      res_valid_d = 1'b1;
      if (cbc) begin
        chain_d = dec ? held_q : core_blk;
      end
    end
  end

  assign sts_o.out_free = !res_valid_q || out_ready_i;
  assign out_valid_o    = res_valid_q;
  assign block_out_o    = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q     <= FIXED_IV;
      res_valid_q <= 1'b0;
    end else begin
      chain_q     <= chain_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    block_q <= block_d;
    held_q  <= held_d;
    rot_q   <= rot_d;
    res_q   <= res_d;
  end

endmodule

// File: rtl/simplified_des_block_cipher.sv
// simplified_des_block_cipher: 12-bit feistel cipher, ecb/cbc, apb configuration
// words: loaded on accept, then one round per cycle through the single shared round unit;
//   the last round merges with write-back and waits for a free output slot; a new word
//   is accepted only in idle, once the previous word has been written back
// reset: asynchronous active low; config back to defaults, chaining value 0xE38
// depends on sdes_pkg, sdes_if, sdes_regs, sdes_ctrl, sdes_dp

module simplified_des_block_cipher #(
  parameter int unsigned MAX_ROUNDS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sdes_in_if.sink                     blk_in_i,
  sdes_out_if.source                  blk_out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sdes_pkg::APB_AW-1:0] paddr,
  input  logic [sdes_pkg::APB_DW-1:0] pwdata,
  output logic [sdes_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import sdes_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // config registers; the user must write them only while the core is idle, the block does not enforce it
  sdes_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: accepts a word in idle, counts rounds, waits for the output slot
  sdes_ctrl #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (blk_in_i.valid),
    .in_ready_o (blk_in_i.ready),
    .cfg_i      (cfg),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: round unit, chaining register and the output register that
  // decouples a stalled consumer from the next incoming word
  sdes_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .block_in_i      (blk_in_i.block_in),
    .restart_chain_i (blk_in_i.restart_chain),
    .out_valid_o     (blk_out_o.valid),
    .out_ready_i     (blk_out_o.ready),
    .block_out_o     (blk_out_o.block_out)
  );

endmodule

// File: sim/tb_simplified_des_block_cipher.sv
`timescale 1ns / 100ps
// tb_simplified_des_block_cipher: self-checking bench for the 12-bit feistel cipher
// drives words through the valid-ready channels, configures over apb, predicts every result
// depends on sdes_pkg, sdes_if and the simplified_des_block_cipher rtl

module tb_simplified_des_block_cipher;
  import sdes_pkg::*;

  // mode codes as they appear in the decrypt_select and chain_mode registers
  localparam bit ENCRYPT = 1'b0;
  localparam bit DECRYPT = 1'b1;
  localparam bit ECB     = 1'b0;
  localparam bit CBC     = 1'b1;

  // an index past the register file, the block must ignore writes to it
  localparam logic [2:0] REG_UNMAPPED = 3'd6;

  localparam int ROUND_CAP    = 16;
  localparam int CLK_HALF     = 4;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 400;
  // word count window in which neither side idles
  localparam int CALM_FROM    = 600;
  localparam int CALM_TO      = 800;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_WORDS  = 96;

  // substitution tables, upper nibble and lower nibble of the expanded half
  localparam logic [2:0] SUB_HI [16] = '{
    3'd5, 3'd2, 3'd1, 3'd6, 3'd3, 3'd4, 3'd7, 3'd0,
    3'd1, 3'd4, 3'd6, 3'd2, 3'd0, 3'd7, 3'd5, 3'd3
  };
  localparam logic [2:0] SUB_LO [16] = '{
    3'd4, 3'd0, 3'd6, 3'd5, 3'd7, 3'd1, 3'd3, 3'd2,
    3'd5, 3'd3, 3'd0, 3'd7, 3'd6, 3'd2, 3'd1, 3'd4
  };

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    logic             restart;
  } blk_word_t;

  logic clk_i;
  logic rst_n;

  // apb side
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  sdes_in_if  in_bus ();
  sdes_out_if out_bus ();

  simplified_des_block_cipher dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_n),
    .blk_in_i  (in_bus),
    .blk_out_o (out_bus),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // shadow of the register file and of the chaining register
  logic [KEY_W-1:0] key_q;
  logic [RC_W-1:0]  rounds_q;
  logic             decrypt_q;
  logic             cbc_q;
  logic [BLK_W-1:0] iv_q;
  logic [BLK_W-1:0] chain_q;

  blk_word_t        pending_words[$];
  logic [BLK_W-1:0] expected_blocks[$];

  int words_checked;
  int err_count;
  int cycle_count;
  int hold_left;
  bit held_once;

  // low phase first so the first rising edge falls inside reset
  always begin
    clk_i = 1'b0;
    #CLK_HALF;
    clk_i = 1'b1;
    #CLK_HALF;
  end

  // ---------------------------------------------------------------------------
  // cipher prediction
  // ---------------------------------------------------------------------------

  // round rn (from 1) takes the key rotated left by (rn-1) mod 9, top 8 bits
  function automatic logic [RK_W-1:0] round_subkey(input logic [KEY_W-1:0] k, input int rn);
    int               rot;
    logic [KEY_W-1:0] rk9;
    rot = (rn - 1) % KEY_W;
    rk9 = (k << rot) | (k >> (KEY_W - rot));
    return rk9[KEY_W-1:1];
  endfunction

  // expand 6 to 8 bits, mix in the round key, two 4-to-3 substitutions
  function automatic logic [HALF_W-1:0] mix_half(input logic [HALF_W-1:0] r,
                                                 input logic [RK_W-1:0] rk);
    logic [RK_W-1:0] e;
    e = {r[5], r[4], r[2], r[3], r[2], r[3], r[1], r[0]} ^ rk;
    return {SUB_HI[e[7:4]], SUB_LO[e[3:0]]};
  endfunction

  // decryption swaps halves around the rounds and walks the keys backwards
  function automatic logic [BLK_W-1:0] cipher_rounds(input logic [BLK_W-1:0] b,
                                                     input bit dec);
    int                n;
    int                rn;
    logic [HALF_W-1:0] l;
    logic [HALF_W-1:0] r;
    logic [BLK_W-1:0]  s;
    n = (int'(rounds_q) > ROUND_CAP) ? ROUND_CAP : int'(rounds_q);
    s = dec ? {b[HALF_W-1:0], b[BLK_W-1:HALF_W]} : b;
    for (int j = 1; j <= n; j++) begin
      rn = dec ? (n - j + 1) : j;
      l  = s[BLK_W-1:HALF_W];
      r  = s[HALF_W-1:0];
      s  = {r, l ^ mix_half(r, round_subkey(key_q, rn))};
    end
    return dec ? {s[HALF_W-1:0], s[BLK_W-1:HALF_W]} : s;
  endfunction

  // result of one accepted word, advancing the chaining register
  function automatic logic [BLK_W-1:0] predict_block(input logic [BLK_W-1:0] blk,
                                                     input logic restart);
    logic [BLK_W-1:0] res;
    if (restart) begin
      chain_q = iv_q;
    end
    if (cbc_q == ECB) begin
      res = cipher_rounds(blk, decrypt_q);
    end else if (decrypt_q == ENCRYPT) begin
      res     = cipher_rounds(blk ^ chain_q, ENCRYPT);
      chain_q = res;
    end else begin
      res     = cipher_rounds(blk, DECRYPT) ^ chain_q;
      chain_q = blk;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: offers queued words, predicts on every accepted one
  // ---------------------------------------------------------------------------

  function automatic bit calm_window();
    return words_checked >= CALM_FROM && words_checked < CALM_TO;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_blocks.push_back(predict_block(in_bus.block_in, in_bus.restart_chain));
      end
      // a word still waiting for ready stays on the bus untouched
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_words.size() != 0 && (calm_window() || $urandom_range(0, 99) >= 10)) begin
          in_bus.valid         <= 1'b1;
          in_bus.block_in      <= pending_words[0].blk;
          in_bus.restart_chain <= pending_words[0].restart;
          void'(pending_words.pop_front());
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result ready: random stalls plus one long hold-off so the input backs up
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_left     <= 0;
      held_once     <= 1'b0;
    end else if (hold_left != 0) begin
      out_bus.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!held_once && words_checked >= HOLD_AT) begin
      out_bus.ready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      held_once     <= 1'b1;
    end else begin
      out_bus.ready <= calm_window() || $urandom_range(0, 99) >= 10;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: in-order compare against the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t unexpected word: expected none, actual block_out %03h",
                 $time, out_bus.block_out);
        err_count++;
      end else begin
        if (out_bus.block_out !== expected_blocks[0]) begin
          $display("%0t block_out mismatch: expected %03h, actual %03h",
                   $time, expected_blocks[0], out_bus.block_out);
          err_count++;
        end
        void'(expected_blocks.pop_front());
      end
      words_checked <= words_checked + 1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // configuration and phase sequencing
  // ---------------------------------------------------------------------------

  // setup then access; the shadow follows at the edge that commits the write
  task automatic cfg_write(input logic [2:0] idx, input logic [APB_DW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_KEY:    key_q     = val[KEY_W-1:0];
      REG_ROUNDS: rounds_q  = val[RC_W-1:0];
      REG_DECR:   decrypt_q = val[0];
      REG_CHAIN:  cbc_q     = val[0];
      REG_IV:     iv_q      = val[BLK_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_mode(input logic [KEY_W-1:0] k, input logic [RC_W-1:0] n,
                          input bit dec, input bit cbc, input logic [BLK_W-1:0] iv);
    cfg_write(REG_KEY, APB_DW'(k));
    cfg_write(REG_ROUNDS, APB_DW'(n));
    cfg_write(REG_DECR, APB_DW'(dec));
    cfg_write(REG_CHAIN, APB_DW'(cbc));
    cfg_write(REG_IV, APB_DW'(iv));
    // queue pushes happen off the rising edge, away from the driver
    @(negedge clk_i);
  endtask

  // block idle: everything offered, accepted and answered
  task automatic drain();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_bus.valid || expected_blocks.size() != 0);
  endtask

  function automatic void push_word(input logic [BLK_W-1:0] blk, input logic restart);
    blk_word_t w;
    w.blk     = blk;
    w.restart = restart;
    pending_words.push_back(w);
  endfunction

  initial begin
    logic [KEY_W-1:0] k;
    logic [RC_W-1:0]  n;
    logic [BLK_W-1:0] iv;

    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_bus.valid         = 1'b0;
    in_bus.block_in      = '0;
    in_bus.restart_chain = 1'b0;
    out_bus.ready        = 1'b0;
    words_checked        = 0;
    err_count            = 0;
    cycle_count          = 0;
    hold_left            = 0;
    held_once            = 1'b0;

    // reset values of the register file and chaining register
    key_q     = '0;
    rounds_q  = RC_W'(4);
    decrypt_q = ENCRYPT;
    cbc_q     = ECB;
    iv_q      = FIXED_IV;
    chain_q   = FIXED_IV;

    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // reset configuration; restart in ecb still reloads the chaining value
    push_word(12'h000, 1'b0);
    push_word(12'hFFF, 1'b1);
    drain();

    // zero rounds: core is identity, cbc xor still applies, full key
    set_mode(9'h1FF, 5'd0, ENCRYPT, CBC, FIXED_IV);
    push_word(12'hFFF, 1'b0);
    push_word(12'h000, 1'b0);
    drain();

    // round count above the cap saturates; new iv not used until a restart
    set_mode(9'h155, 5'd31, DECRYPT, CBC, 12'h000);
    push_word(12'hAAA, 1'b0);
    push_word(12'h555, 1'b0);
    push_word(12'h123, 1'b1);
    drain();

    // full sixteen rounds in ecb, key schedule wraps past nine
    set_mode(9'h0AA, 5'd16, ENCRYPT, ECB, 12'hFFF);
    push_word(12'h000, 1'b0);
    push_word(12'hFFF, 1'b0);
    push_word(12'h800, 1'b0);
    push_word(12'h001, 1'b0);
    drain();

    // single round decrypt in ecb
    set_mode(9'h000, 5'd1, DECRYPT, ECB, 12'h000);
    push_word(12'hFFF, 1'b0);
    push_word(12'h000, 1'b1);
    drain();

    // ten rounds cbc encrypt from an all-ones iv
    set_mode(9'h1FF, 5'd10, ENCRYPT, CBC, 12'hFFF);
    push_word(12'hFFF, 1'b1);
    push_word(12'hFFF, 1'b0);
    push_word(12'h7E1, 1'b0);
    drain();

    // a write past the register file changes nothing
    set_mode(9'h0F0, 5'd17, DECRYPT, CBC, 12'h5A5);
    cfg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
    @(negedge clk_i);
    push_word(12'h3C3, 1'b1);
    push_word(12'hC3C, 1'b0);
    push_word(12'h000, 1'b0);
    drain();

    // random phases, each with its own setting; extremes mixed in
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 4)
        0:       k = '0;
        1:       k = 9'h1FF;
        default: k = KEY_W'($urandom_range(0, 511));
      endcase
      if (p == 2)
        n = 5'd16;
      else if (p == 5)
        n = 5'd0;
      else if (p == 8)
        n = RC_W'($urandom_range(17, 31));
      else
        n = RC_W'($urandom_range(0, 16));
      if (p == 3)
        iv = 12'hFFF;
      else if (p == 6)
        iv = 12'h000;
      else
        iv = BLK_W'($urandom_range(0, 4095));
      set_mode(k, n, bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)), iv);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        push_word(BLK_W'($urandom_range(0, 4095)),
                  (i == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 9) == 0);
      end
      drain();
    end

    // let anything spurious surface before the verdict
    repeat (2 * ROUND_CAP + 8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
